// ===== hdl/shuffled_batch_index_sequencer_top_defines.svh =====
// ----------------------------------------------------------------------------
// shuffled batch index sequencer assertion macros
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_BATCH_INDEX_SEQUENCER_TOP_DEFINES_SVH
`define SHUFFLED_BATCH_INDEX_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define SBIS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbis assertion failed");

// next-cycle implication
`define SBIS_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbis assertion failed");

`endif

// ===== hdl/sbis_pkg.sv =====
// ----------------------------------------------------------------------------
// sbis_pkg
// Sizes, codes, port structs and the xorshift32 step shared by the sequencer.
// ----------------------------------------------------------------------------
package sbis_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int MAX_BATCH   = 64;

   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int COUNT_REG_W = 11;
   localparam int BS_W        = 7;
   localparam int SLOT_W      = 6;
   localparam int OPCODE_W    = 2;
   localparam int SEED_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int PROD_W      = CNT_W + BS_W;

   localparam int REM_DIGIT_W = 8;
   localparam int REM_STEPS   = SEED_W / REM_DIGIT_W;
   localparam int REM_STEP_W  = $clog2(REM_STEPS);

   localparam int XS_A = 13;
   localparam int XS_B = 17;
   localparam int XS_C = 5;
   localparam logic [SEED_W-1:0] SEED_DEFAULT = 32'd42;

   localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic [BS_W-1:0]        BS_RESET    = 7'd1;

   localparam logic [OPCODE_W-1:0] OP_INIT      = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RESHUFFLE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_NEXT      = 2'd2;

   localparam logic [STATUS_W-1:0] ST_SAMPLE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BATCH_SIZE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SHUFFLE_EN   = 2'd2;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              start;
      logic [SEED_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] remainder;
   } rem_rsp_type;

   function automatic logic [SEED_W-1:0] rng_next(input logic [SEED_W-1:0] x);
      logic [SEED_W-1:0] y;
      y = x ^ (x << XS_A);
      y = y ^ (y >> XS_B);
      y = y ^ (y << XS_C);
      return y;
   endfunction

endpackage

// ===== hdl/sbis_perm_mem.sv =====
// ----------------------------------------------------------------------------
// sbis_perm_mem
// Permutation table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbis_perm_mem (
   input  logic                     clock,
   input  sbis_pkg::mem_wr_type     wr,
   input  sbis_pkg::mem_rd_type     rd,
   output logic [sbis_pkg::IDX_W-1:0] rd_data
);
   import sbis_pkg::*;

   logic [IDX_W-1:0] perm_mem [MAX_SAMPLES];
   logic [IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         perm_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= perm_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sbis_rem_unit.sv =====
// ----------------------------------------------------------------------------
// sbis_rem_unit
// Restoring remainder of a 32-bit value by the shuffle bound, one byte a cycle.
// ----------------------------------------------------------------------------
module sbis_rem_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  sbis_pkg::rem_req_type req,
   output sbis_pkg::rem_rsp_type rsp
);
   import sbis_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [REM_STEP_W-1:0] cnt_ff, cnt_in;
   logic [SEED_W-1:0]     dvd_ff, dvd_in;
   logic [CNT_W-1:0]      dsr_ff, dsr_in;
   logic [IDX_W-1:0]      rem_ff, rem_in;
   logic [IDX_W-1:0]      rem_step;

   always_comb begin
      logic [CNT_W-1:0] t;
      rem_step = rem_ff;
      for (int k = 0; k < REM_DIGIT_W; k++) begin
         t = {rem_step, dvd_ff[SEED_W-1-k]};
         if (t >= dsr_ff) begin
            rem_step = IDX_W'(t - dsr_ff);
         end else begin
            rem_step = t[IDX_W-1:0];
         end
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = req.dividend;
         dsr_in = req.divisor;
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = rem_step;
         dvd_in = dvd_ff << REM_DIGIT_W;
         cnt_in = cnt_ff + REM_STEP_W'(1);
         if (cnt_ff == REM_STEP_W'(REM_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== hdl/shuffled_batch_index_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// shuffled_batch_index_sequencer_top
// Commands are taken when start is high and busy is low; busy stays high until
// the command is finished. Results come out on rsp_valid for one cycle each and
// cannot be held off. Init writes the identity table over sample_count entries;
// with shuffling on, init and reshuffle then run one Fisher-Yates pass, each
// swap using a one-byte-per-cycle remainder unit followed by two reads and two
// writes on the table's read and write ports. Next streams its batch one result
// per cycle. The table has no reset and must be initialised before next.
// ----------------------------------------------------------------------------
module shuffled_batch_index_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sbis_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [sbis_pkg::SEED_W-1:0]         req_seed,
   output logic                                rsp_valid,
   output logic [sbis_pkg::IDX_W-1:0]          rsp_sample_index,
   output logic [sbis_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [sbis_pkg::IDX_W-1:0]          rsp_batch_number,
   output logic                                rsp_last,
   output logic [sbis_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbis_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sbis_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sbis_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_FILL     = 13'b0000000000010,
      S_SH_INIT  = 13'b0000000000100,
      S_SH_START = 13'b0000000001000,
      S_SH_REM   = 13'b0000000010000,
      S_SH_RDJ   = 13'b0000000100000,
      S_SH_WR1   = 13'b0000001000000,
      S_SH_WR2   = 13'b0000010000000,
      S_DONE     = 13'b0000100000000,
      S_NX_MUL   = 13'b0001000000000,
      S_NX_CHK   = 13'b0010000000000,
      S_NX_RD    = 13'b0100000000000,
      S_NX_FLUSH = 13'b1000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_REG_W-1:0] count_reg_ff, count_reg_in;
   logic [BS_W-1:0]       bs_reg_ff, bs_reg_in;
   logic                  shuffle_en_ff, shuffle_en_in;
   logic [CNT_W-1:0]      bc_ff, bc_in;
   logic [SEED_W-1:0]     x_ff, x_in;
   logic [SEED_W-1:0]     seed_ff, seed_in;
   logic [CNT_W-1:0]      i_ff, i_in;
   logic [IDX_W-1:0]      j_ff, j_in;
   logic [IDX_W-1:0]      a_ff, a_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [BS_W-1:0]       len_ff, len_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [IDX_W-1:0]      pend_bn_ff, pend_bn_in;
   logic                  pend_last_ff, pend_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [IDX_W-1:0]      rsp_bn_ff, rsp_bn_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]      n_eff;
   logic [BS_W-1:0]       bs_eff;
   logic [CNT_W-1:0]      i_m1;
   logic [CNT_W-1:0]      left;
   logic [SEED_W-1:0]     x_step;
   logic                  single_valid;
   logic [STATUS_W-1:0]   single_status;
   mem_wr_type            wr_req;
   mem_rd_type            rd_req;
   logic [IDX_W-1:0]      rd_data;
   rem_req_type           rem_req;
   rem_rsp_type           rem_rsp;

   sbis_perm_mem u_perm_mem (
      .clock   (clock),
      .wr      (wr_req),
      .rd      (rd_req),
      .rd_data (rd_data)
   );

   sbis_rem_unit u_rem_unit (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   assign n_eff = (32'(count_reg_ff) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                          : CNT_W'(count_reg_ff);

   always_comb begin
      priority if (bs_reg_ff == '0) begin
         bs_eff = BS_W'(1);
      end else if (32'(bs_reg_ff) > 32'(MAX_BATCH)) begin
         bs_eff = BS_W'(MAX_BATCH);
      end else begin
         bs_eff = bs_reg_ff;
      end
   end

   assign i_m1   = i_ff - CNT_W'(1);
   assign left   = n_eff - prod_ff[CNT_W-1:0];
   assign x_step = rng_next(x_ff);

   // register file
   always_comb begin
      count_reg_in  = count_reg_ff;
      bs_reg_in     = bs_reg_ff;
      shuffle_en_in = shuffle_en_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SAMPLE_COUNT: count_reg_in  = csr_data[COUNT_REG_W-1:0];
            REG_BATCH_SIZE:   bs_reg_in     = csr_data[BS_W-1:0];
            REG_SHUFFLE_EN:   shuffle_en_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      bc_in         = bc_ff;
      x_in          = x_ff;
      seed_in       = seed_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      a_in          = a_ff;
      fill_in       = fill_ff;
      prod_in       = prod_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      slot_in       = slot_ff;
      pend_valid_in = 1'b0;
      pend_slot_in  = pend_slot_ff;
      pend_bn_in    = pend_bn_ff;
      pend_last_in  = pend_last_ff;
      single_valid  = 1'b0;
      single_status = ST_DONE;
      wr_req        = '0;
      rd_req        = '0;
      rem_req       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               seed_in = req_seed;
               unique case (req_opcode)
                  OP_INIT: begin
                     bc_in   = '0;
                     fill_in = '0;
                     if (n_eff != '0) begin
                        state_in = S_FILL;
                     end else begin
                        state_in = shuffle_en_ff ? S_SH_INIT : S_DONE;
                     end
                  end
                  OP_RESHUFFLE: begin
                     bc_in    = '0;
                     state_in = shuffle_en_ff ? S_SH_INIT : S_DONE;
                  end
                  OP_NEXT: state_in = S_NX_MUL;
                  default: ;
               endcase
            end
         end
         S_FILL: begin
            wr_req.en   = 1'b1;
            wr_req.addr = fill_ff[IDX_W-1:0];
            wr_req.data = fill_ff[IDX_W-1:0];
            fill_in     = fill_ff + CNT_W'(1);
            if (fill_ff + CNT_W'(1) == n_eff) begin
               state_in = shuffle_en_ff ? S_SH_INIT : S_DONE;
            end
         end
         S_SH_INIT: begin
            x_in     = (seed_ff == '0) ? SEED_DEFAULT : seed_ff;
            i_in     = n_eff;
            state_in = (n_eff > CNT_W'(1)) ? S_SH_START : S_DONE;
         end
         S_SH_START: begin
            x_in             = x_step;
            rem_req.start    = 1'b1;
            rem_req.dividend = x_step;
            rem_req.divisor  = i_ff;
            rd_req.en        = 1'b1;
            rd_req.addr      = i_m1[IDX_W-1:0];
            state_in         = S_SH_REM;
         end
         S_SH_REM: begin
            if (rem_rsp.done) begin
               j_in     = rem_rsp.remainder;
               state_in = S_SH_RDJ;
            end
         end
         S_SH_RDJ: begin
            a_in        = rd_data;
            rd_req.en   = 1'b1;
            rd_req.addr = j_ff;
            state_in    = S_SH_WR1;
         end
         S_SH_WR1: begin
            wr_req.en   = 1'b1;
            wr_req.addr = i_m1[IDX_W-1:0];
            wr_req.data = rd_data;
            state_in    = S_SH_WR2;
         end
         S_SH_WR2: begin
            wr_req.en   = 1'b1;
            wr_req.addr = j_ff;
            wr_req.data = a_ff;
            i_in        = i_m1;
            state_in    = (i_ff == CNT_W'(2)) ? S_DONE : S_SH_START;
         end
         S_DONE: begin
            single_valid  = 1'b1;
            single_status = ST_DONE;
            state_in      = S_IDLE;
         end
         S_NX_MUL: begin
            prod_in  = PROD_W'(bc_ff) * PROD_W'(bs_eff);
            state_in = S_NX_CHK;
         end
         S_NX_CHK: begin
            if (prod_ff >= PROD_W'(n_eff)) begin
               single_valid  = 1'b1;
               single_status = ST_EXHAUSTED;
               state_in      = S_IDLE;
            end else begin
               addr_in  = prod_ff[IDX_W-1:0];
               slot_in  = '0;
               len_in   = (32'(left) < 32'(bs_eff)) ? BS_W'(left) : bs_eff;
               state_in = S_NX_RD;
            end
         end
         S_NX_RD: begin
            rd_req.en     = 1'b1;
            rd_req.addr   = addr_ff;
            addr_in       = addr_ff + IDX_W'(1);
            slot_in       = slot_ff + SLOT_W'(1);
            pend_valid_in = 1'b1;
            pend_slot_in  = slot_ff;
            pend_bn_in    = bc_ff[IDX_W-1:0];
            pend_last_in  = (BS_W'(slot_ff) + BS_W'(1) == len_ff);
            if (BS_W'(slot_ff) + BS_W'(1) == len_ff) begin
               bc_in    = bc_ff + CNT_W'(1);
               state_in = S_NX_FLUSH;
            end
         end
         S_NX_FLUSH: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = pend_valid_ff | single_valid;
      if (pend_valid_ff) begin
         rsp_index_in  = rd_data;
         rsp_slot_in   = pend_slot_ff;
         rsp_bn_in     = pend_bn_ff;
         rsp_last_in   = pend_last_ff;
         rsp_status_in = ST_SAMPLE;
      end else begin
         rsp_index_in  = '0;
         rsp_slot_in   = '0;
         rsp_bn_in     = '0;
         rsp_last_in   = 1'b1;
         rsp_status_in = single_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_reg_ff  <= COUNT_RESET;
         bs_reg_ff     <= BS_RESET;
         shuffle_en_ff <= 1'b0;
         bc_ff         <= '0;
         x_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_reg_ff  <= count_reg_in;
         bs_reg_ff     <= bs_reg_in;
         shuffle_en_ff <= shuffle_en_in;
         bc_ff         <= bc_in;
         x_ff          <= x_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      seed_ff       <= seed_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      a_ff          <= a_in;
      fill_ff       <= fill_in;
      prod_ff       <= prod_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      slot_ff       <= slot_in;
      pend_slot_ff  <= pend_slot_in;
      pend_bn_ff    <= pend_bn_in;
      pend_last_ff  <= pend_last_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_bn_ff     <= rsp_bn_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_index = rsp_index_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_batch_number = rsp_bn_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== hdl/sbis_checker.sv =====
// ----------------------------------------------------------------------------
// sbis_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "shuffled_batch_index_sequencer_top_defines.svh"

module sbis_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [sbis_pkg::OPCODE_W-1:0]    req_opcode,
   input logic                             rsp_valid,
   input logic [sbis_pkg::IDX_W-1:0]       rsp_sample_index,
   input logic [sbis_pkg::SLOT_W-1:0]      rsp_slot,
   input logic [sbis_pkg::IDX_W-1:0]       rsp_batch_number,
   input logic                             rsp_last,
   input logic [sbis_pkg::STATUS_W-1:0]    rsp_status
);
   import sbis_pkg::*;

   // done and exhausted results are single, zero-payload transfers
   `SBIS_ASSERT_IMP(a_status_single, rsp_valid && rsp_status != ST_SAMPLE, rsp_last && rsp_sample_index == '0 && rsp_slot == '0 && rsp_batch_number == '0)

   // a real command always occupies the block
   `SBIS_ASSERT_NXT(a_cmd_busy, start && !busy && (req_opcode == OP_INIT || req_opcode == OP_RESHUFFLE || req_opcode == OP_NEXT), busy)

   // a batch comes out back to back with rising slots
   `SBIS_ASSERT_NXT(a_burst_slots, rsp_valid && !rsp_last, rsp_valid && rsp_status == ST_SAMPLE && rsp_slot == SLOT_W'($past(rsp_slot) + 1'b1))

   // mid-batch the block is still busy
   `SBIS_ASSERT_IMP(a_burst_busy, rsp_valid && !rsp_last, busy)

endmodule

bind shuffled_batch_index_sequencer_top sbis_checker u_sbis_checker (.*);
